// ----- rtl/igtt_pkg.sv -----
// shared types and constants of the iou greedy track table
package igtt_pkg;

    localparam int TRACK_SLOTS_DEF = 256;
    localparam int COORD_BITS_DEF  = 12;

    localparam logic [15:0] THR_RESET = 16'd19661;
    localparam logic [7:0]  AGE_RESET = 8'd30;

    // configuration register indexes
    localparam logic [1:0] REG_IOU_THRESHOLD = 2'd0;
    localparam logic [1:0] REG_MAX_AGE       = 2'd1;

    typedef enum logic [1:0] {
        KIND_DET   = 2'd0,
        KIND_EOF   = 2'd1,
        KIND_CLEAR = 2'd2,
        KIND_NONE  = 2'd3
    } igtt_kind_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_COMMIT,
        ST_AGE,
        ST_DONE
    } igtt_state_t;

    typedef struct packed {
        igtt_kind_t  kind;
        logic [7:0]  det_class;
        logic [11:0] box_left;
        logic [11:0] box_top;
        logic [11:0] box_width;
        logic [11:0] box_height;
    } item_t;

    typedef struct packed {
        logic [15:0] assigned_id;
        logic        is_new;
        logic        table_full;
        logic [8:0]  live_count;
        logic [15:0] ids_issued;
    } result_t;

    // control tag travelling with a slot through the overlap pipeline
    typedef struct packed {
        logic valid;
        logic elig;
    } tag_t;

endpackage

// ----- rtl/iou_greedy_track_table.sv -----
// Track table matched greedily by box overlap. One item is worked on at a time and gives
// one result. The track state lives in a single memory of TRACK_SLOTS entries read through
// a registered port, so every item that touches the table is a sweep over it: a detection
// spaces its slot reads into the overlap pipeline so that the best candidate so far is
// settled before the next cross product is formed; an end-of-frame item reads and writes
// back one slot a cycle; a clear item rewrites every slot; an unknown kind answers without
// touching the table. After reset the same clearing pass runs with item_stall high;
// configuration writes are taken at any time.
module iou_greedy_track_table #(
    parameter int TRACK_SLOTS = igtt_pkg::TRACK_SLOTS_DEF,
    parameter int COORD_BITS  = igtt_pkg::COORD_BITS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_stall,
    input  igtt_pkg::item_t   item,
    output logic              result_valid,
    input  logic              result_stall,
    output igtt_pkg::result_t result,
    input  logic              cfg_write,
    input  logic [1:0]        cfg_index,
    input  logic [15:0]       cfg_data
);

    localparam int CB       = COORD_BITS;
    localparam int AW       = $clog2(TRACK_SLOTS);
    localparam int CW       = $clog2(TRACK_SLOTS + 1);
    localparam int SCAN_END = 2 * TRACK_SLOTS + 4;
    localparam int SW       = $clog2(SCAN_END + 1);
    localparam int IN_W     = 2 * CB + 2;
    localparam int UN_W     = 2 * CB + 1;
    localparam int PT_W     = UN_W + 17;
    localparam int PC_W     = IN_W + UN_W;
    localparam int BOX_W    = 4 * CB;
    localparam int EW       = BOX_W + 34;
    localparam int CLS_LO   = BOX_W;
    localparam int ID_LO    = BOX_W + 8;
    localparam int AGE_LO   = BOX_W + 24;
    localparam int FRZ_BIT  = BOX_W + 32;
    localparam int ACT_BIT  = BOX_W + 33;

    igtt_pkg::igtt_state_t state_reg, state_next;
    logic [SW-1:0]  step_reg;
    logic           reply_reg;

    logic [EW-1:0]  mem [TRACK_SLOTS];
    logic [EW-1:0]  q_reg;
    logic           rd_v_reg;
    logic [AW-1:0]  rd_idx_reg;
    logic           rd_issue;
    logic [AW-1:0]  rd_addr;
    logic           wr_en;
    logic [AW-1:0]  wr_addr;
    logic [EW-1:0]  wr_data;

    logic           q_active, q_frozen;
    logic [7:0]     q_age, q_cls;
    logic [15:0]    q_ident;
    logic [BOX_W-1:0] q_box;

    logic [15:0]    thr_reg;
    logic [7:0]     max_age_reg;
    logic [15:0]    id_counter_reg;
    logic [CW-1:0]  active_total_reg;

    logic [7:0]       cls_reg;
    logic [BOX_W-1:0] dbox_reg;
    logic [2*CB-1:0]  qa_reg;
    logic [BOX_W-1:0] det_box_in;
    logic [CB-1:0]    in_w, in_h;

    logic            found_reg, free_found_reg;
    logic [AW-1:0]   best_idx_reg, free_idx_reg;
    logic [IN_W-1:0] bi_reg;
    logic [UN_W-1:0] bu_reg;
    logic [15:0]     bident_reg;

    logic [15:0]     asg_reg;
    logic            new_reg, full_reg;
    logic            result_valid_reg;
    igtt_pkg::result_t result_reg;

    logic            accept, res_load, take, opening;
    logic [8:0]      age_inc;
    logic            ageing, retire;
    logic [15:0]     id_after;

    igtt_pkg::tag_t  tag_in, tag_out;
    logic [AW-1:0]   idx_out;
    logic [15:0]     ident_out;
    logic [IN_W-1:0] inter_out;
    logic [UN_W-1:0] union_out;
    logic [PT_W-1:0] thr_lhs, thr_rhs;
    logic [PC_W-1:0] cand_lhs, cand_rhs;

    assign q_active = q_reg[ACT_BIT];
    assign q_frozen = q_reg[FRZ_BIT];
    assign q_age    = q_reg[AGE_LO +: 8];
    assign q_ident  = q_reg[ID_LO +: 16];
    assign q_cls    = q_reg[CLS_LO +: 8];
    assign q_box    = q_reg[BOX_W-1:0];

    // coordinates masked to the configured width
    assign in_w       = CB'(item.box_width);
    assign in_h       = CB'(item.box_height);
    assign det_box_in = {in_h, in_w, CB'(item.box_top), CB'(item.box_left)};

    assign accept   = (state_reg == igtt_pkg::ST_IDLE) && item_valid;
    assign age_inc  = {1'b0, q_age} + 9'd1;
    assign ageing   = q_active && !q_frozen;
    assign retire   = ageing && (age_inc > {1'b0, max_age_reg});
    assign id_after = (id_counter_reg == 16'hFFFF) ? 16'd1 : id_counter_reg + 16'd1;
    assign take     = found_reg ? (cand_lhs > cand_rhs) : (thr_lhs > thr_rhs);
    assign opening  = !found_reg && free_found_reg;

    assign tag_in.valid = rd_v_reg && (state_reg == igtt_pkg::ST_SCAN);
    assign tag_in.elig  = q_active && !q_frozen && (q_cls == cls_reg);

    igtt_overlap_pipe #(
        .COORD_BITS (COORD_BITS),
        .AW         (AW)
    ) u_pipe (
        .clk        (clk),
        .rst_n      (rst_n),
        .tag_in     (tag_in),
        .idx_in     (rd_idx_reg),
        .ident_in   (q_ident),
        .slot_box   (q_box),
        .det_box    (dbox_reg),
        .det_area   (qa_reg),
        .threshold  (thr_reg),
        .best_inter (bi_reg),
        .best_union (bu_reg),
        .tag_out    (tag_out),
        .idx_out    (idx_out),
        .ident_out  (ident_out),
        .inter_out  (inter_out),
        .union_out  (union_out),
        .thr_lhs    (thr_lhs),
        .thr_rhs    (thr_rhs),
        .cand_lhs   (cand_lhs),
        .cand_rhs   (cand_rhs)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            igtt_pkg::ST_CLEAR:
                if (step_reg == SW'(TRACK_SLOTS - 1))
                    state_next = reply_reg ? igtt_pkg::ST_DONE : igtt_pkg::ST_IDLE;
            igtt_pkg::ST_IDLE:
                if (item_valid)
                begin
                    unique case (item.kind)
                        igtt_pkg::KIND_DET:   state_next = igtt_pkg::ST_SCAN;
                        igtt_pkg::KIND_EOF:   state_next = igtt_pkg::ST_AGE;
                        igtt_pkg::KIND_CLEAR: state_next = igtt_pkg::ST_CLEAR;
                        igtt_pkg::KIND_NONE:  state_next = igtt_pkg::ST_DONE;
                        default:              state_next = igtt_pkg::ST_DONE;
                    endcase
                end
            igtt_pkg::ST_SCAN:
                if (step_reg == SW'(SCAN_END))
                    state_next = igtt_pkg::ST_COMMIT;
            igtt_pkg::ST_COMMIT:
                state_next = igtt_pkg::ST_DONE;
            igtt_pkg::ST_AGE:
                if (step_reg == SW'(TRACK_SLOTS))
                    state_next = igtt_pkg::ST_DONE;
            igtt_pkg::ST_DONE:
                if (!result_valid_reg || !result_stall)
                    state_next = igtt_pkg::ST_IDLE;
            default:
                state_next = igtt_pkg::ST_IDLE;
        endcase
    end

    // outputs of the state machine
    always_comb
    begin
        item_stall = 1'b1;
        rd_issue   = 1'b0;
        rd_addr    = '0;
        wr_en      = 1'b0;
        wr_addr    = '0;
        wr_data    = '0;
        res_load   = 1'b0;
        unique case (state_reg)
            igtt_pkg::ST_CLEAR:
            begin
                wr_en   = 1'b1;
                wr_addr = step_reg[AW-1:0];
            end
            igtt_pkg::ST_IDLE:
                item_stall = 1'b0;
            igtt_pkg::ST_SCAN:
            begin
                // spacing the slot reads apart keeps the best candidate current
                rd_issue = !step_reg[0] && (step_reg < SW'(2 * TRACK_SLOTS));
                rd_addr  = step_reg[AW:1];
            end
            igtt_pkg::ST_COMMIT:
            begin
                wr_en   = found_reg || free_found_reg;
                wr_addr = found_reg ? best_idx_reg : free_idx_reg;
                wr_data = {1'b1, 1'b1, 8'd0,
                           found_reg ? bident_reg : id_counter_reg,
                           cls_reg, dbox_reg};
            end
            igtt_pkg::ST_AGE:
            begin
                rd_issue = step_reg < SW'(TRACK_SLOTS);
                rd_addr  = step_reg[AW-1:0];
                wr_en    = rd_v_reg;
                wr_addr  = rd_idx_reg;
                wr_data  = {q_active && !retire, 1'b0,
                            (ageing && !retire) ? age_inc[7:0] : q_age,
                            q_ident, q_cls, q_box};
            end
            igtt_pkg::ST_DONE:
                res_load = !result_valid_reg || !result_stall;
            default:
            begin
                item_stall = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        q_reg      <= mem[rd_addr];
        rd_idx_reg <= rd_addr;
        if (wr_en)
            mem[wr_addr] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= igtt_pkg::ST_CLEAR;
            step_reg         <= '0;
            reply_reg        <= 1'b0;
            rd_v_reg         <= 1'b0;
            found_reg        <= 1'b0;
            free_found_reg   <= 1'b0;
            id_counter_reg   <= 16'd1;
            active_total_reg <= '0;
            thr_reg          <= igtt_pkg::THR_RESET;
            max_age_reg      <= igtt_pkg::AGE_RESET;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_next != state_reg)
                step_reg <= '0;
            else
                step_reg <= step_reg + SW'(1);
            rd_v_reg <= rd_issue;

            if (cfg_write)
            begin
                unique case (cfg_index)
                    igtt_pkg::REG_IOU_THRESHOLD: thr_reg     <= cfg_data;
                    igtt_pkg::REG_MAX_AGE:       max_age_reg <= cfg_data[7:0];
                    default:                     ;
                endcase
            end

            if (accept)
            begin
                found_reg      <= 1'b0;
                free_found_reg <= 1'b0;
                reply_reg      <= (item.kind == igtt_pkg::KIND_CLEAR);
            end

            if (state_reg == igtt_pkg::ST_CLEAR)
            begin
                id_counter_reg   <= 16'd1;
                active_total_reg <= '0;
            end

            if (state_reg == igtt_pkg::ST_SCAN)
            begin
                if (tag_out.valid && tag_out.elig && take)
                    found_reg <= 1'b1;
                // lowest free slot in slot order
                if (rd_v_reg && !q_active && !free_found_reg)
                    free_found_reg <= 1'b1;
            end

            if (state_reg == igtt_pkg::ST_COMMIT && opening)
            begin
                active_total_reg <= active_total_reg + CW'(1);
                id_counter_reg   <= id_after;
            end

            if (state_reg == igtt_pkg::ST_AGE && rd_v_reg && retire)
                active_total_reg <= active_total_reg - CW'(1);

            if (res_load)
                result_valid_reg <= 1'b1;
            else if (result_valid_reg && !result_stall)
                result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cls_reg  <= item.det_class;
            dbox_reg <= det_box_in;
            qa_reg   <= in_w * in_h;
            bi_reg   <= '0;
            bu_reg   <= '0;
            asg_reg  <= '0;
            new_reg  <= 1'b0;
            full_reg <= 1'b0;
        end

        if (state_reg == igtt_pkg::ST_SCAN)
        begin
            if (tag_out.valid && tag_out.elig && take)
            begin
                best_idx_reg <= idx_out;
                bi_reg       <= inter_out;
                bu_reg       <= union_out;
                bident_reg   <= ident_out;
            end
            if (rd_v_reg && !q_active && !free_found_reg)
                free_idx_reg <= rd_idx_reg;
        end

        if (state_reg == igtt_pkg::ST_COMMIT)
        begin
            asg_reg  <= found_reg ? bident_reg : (opening ? id_counter_reg : 16'd0);
            new_reg  <= opening;
            full_reg <= !found_reg && !free_found_reg;
        end

        if (res_load)
        begin
            result_reg.assigned_id <= asg_reg;
            result_reg.is_new      <= new_reg;
            result_reg.table_full  <= full_reg;
            result_reg.live_count  <= 9'(active_total_reg);
            result_reg.ids_issued  <= id_counter_reg - 16'd1;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

// ----- rtl/igtt_overlap_pipe.sv -----
// overlap pipeline: intersection, union and the cross products for one slot
module igtt_overlap_pipe #(
    parameter int COORD_BITS = igtt_pkg::COORD_BITS_DEF,
    parameter int AW         = 8
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  igtt_pkg::tag_t              tag_in,
    input  logic [AW-1:0]               idx_in,
    input  logic [15:0]                 ident_in,
    input  logic [4*COORD_BITS-1:0]     slot_box,
    input  logic [4*COORD_BITS-1:0]     det_box,
    input  logic [2*COORD_BITS-1:0]     det_area,
    input  logic [15:0]                 threshold,
    input  logic [2*COORD_BITS+1:0]     best_inter,
    input  logic [2*COORD_BITS:0]       best_union,
    output igtt_pkg::tag_t              tag_out,
    output logic [AW-1:0]               idx_out,
    output logic [15:0]                 ident_out,
    output logic [2*COORD_BITS+1:0]     inter_out,
    output logic [2*COORD_BITS:0]       union_out,
    output logic [2*COORD_BITS+17:0]    thr_lhs,
    output logic [2*COORD_BITS+17:0]    thr_rhs,
    output logic [4*COORD_BITS+2:0]     cand_lhs,
    output logic [4*COORD_BITS+2:0]     cand_rhs
);

    localparam int CB   = COORD_BITS;
    localparam int IN_W = 2 * CB + 2;
    localparam int UN_W = 2 * CB + 1;
    localparam int PT_W = UN_W + 17;
    localparam int PC_W = IN_W + UN_W;

    logic [CB-1:0] sl, st, sw, sh, dl, dt, dw, dh;
    logic [CB-1:0] x1, y1;
    logic [CB:0]   sr, sb, dr, db, x2, y2, iw, ih;

    igtt_pkg::tag_t tag2_reg, tag3_reg, tag4_reg, tag5_reg;
    logic [AW-1:0]  idx2_reg, idx3_reg, idx4_reg, idx5_reg;
    logic [15:0]    ident2_reg, ident3_reg, ident4_reg, ident5_reg;
    logic [CB:0]    iw2_reg, ih2_reg;
    logic [2*CB-1:0] pa2_reg, pa3_reg;
    logic [IN_W-1:0] inter3_reg, inter4_reg, inter5_reg;
    logic [UN_W-1:0] uni4_reg, uni5_reg;
    logic [PT_W-1:0] thr_lhs_reg, thr_rhs_reg;
    logic [PC_W-1:0] cand_lhs_reg, cand_rhs_reg;

    assign {sh, sw, st, sl} = slot_box;
    assign {dh, dw, dt, dl} = det_box;

    always_comb
    begin
        x1 = (sl > dl) ? sl : dl;
        y1 = (st > dt) ? st : dt;
        sr = {1'b0, sl} + {1'b0, sw};
        dr = {1'b0, dl} + {1'b0, dw};
        sb = {1'b0, st} + {1'b0, sh};
        db = {1'b0, dt} + {1'b0, dh};
        x2 = (sr < dr) ? sr : dr;
        y2 = (sb < db) ? sb : db;
        iw = (x2 > {1'b0, x1}) ? (x2 - {1'b0, x1}) : '0;
        ih = (y2 > {1'b0, y1}) ? (y2 - {1'b0, y1}) : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag2_reg <= '0;
            tag3_reg <= '0;
            tag4_reg <= '0;
            tag5_reg <= '0;
        end
        else
        begin
            tag2_reg <= tag_in;
            tag3_reg <= tag2_reg;
            tag4_reg <= tag3_reg;
            tag5_reg <= tag4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        idx2_reg     <= idx_in;
        ident2_reg   <= ident_in;
        iw2_reg      <= iw;
        ih2_reg      <= ih;
        pa2_reg      <= sw * sh;

        idx3_reg     <= idx2_reg;
        ident3_reg   <= ident2_reg;
        inter3_reg   <= iw2_reg * ih2_reg;
        pa3_reg      <= pa2_reg;

        idx4_reg     <= idx3_reg;
        ident4_reg   <= ident3_reg;
        inter4_reg   <= inter3_reg;
        // intersection never exceeds either area, so no underflow
        uni4_reg     <= UN_W'(pa3_reg) + UN_W'(det_area) - UN_W'(inter3_reg);

        idx5_reg     <= idx4_reg;
        ident5_reg   <= ident4_reg;
        inter5_reg   <= inter4_reg;
        uni5_reg     <= uni4_reg;
        thr_lhs_reg  <= {inter4_reg, 16'h0000};
        thr_rhs_reg  <= PT_W'(threshold * uni4_reg);
        cand_lhs_reg <= inter4_reg * best_union;
        cand_rhs_reg <= best_inter * uni4_reg;
    end

    assign tag_out   = tag5_reg;
    assign idx_out   = idx5_reg;
    assign ident_out = ident5_reg;
    assign inter_out = inter5_reg;
    assign union_out = uni5_reg;
    assign thr_lhs   = thr_lhs_reg;
    assign thr_rhs   = thr_rhs_reg;
    assign cand_lhs  = cand_lhs_reg;
    assign cand_rhs  = cand_rhs_reg;

endmodule

// ----- rtl/igtt_checker.sv -----
// port checker for the iou greedy track table, bound to the top level
module igtt_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              item_valid,
    input logic              item_stall,
    input logic              result_valid,
    input logic              result_stall,
    input igtt_pkg::result_t result
);

    // a held result keeps its value
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
    else $error("stalled result changed");

    // one item at a time: after a transaction the input is held off
    assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall |=> item_stall)
    else $error("second item taken while one is at work");

    // a new track carries a real id and is never a full-table drop
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.is_new |-> result.assigned_id != 16'd0 && !result.table_full)
    else $error("new track with id zero or table full");

    // a dropped detection gets no id
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.table_full |-> result.assigned_id == 16'd0)
    else $error("dropped detection carries an id");

endmodule

bind iou_greedy_track_table igtt_checker u_igtt_checker (.*);

// ----- bench/iou_greedy_track_table_tb.sv -----
// self-checking bench for the iou greedy track table: directed cases, then random frames
module iou_greedy_track_table_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS = 256;
    localparam int CYCLE_LIMIT = 4000000;
    localparam int SETTLE_CYCLES = 2 * SLOTS + 40;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              item_valid = 1'b0;
    logic              item_stall;
    igtt_pkg::item_t   item = '0;
    logic              result_valid;
    logic              result_stall = 1'b0;
    igtt_pkg::result_t result;
    logic              cfg_write = 1'b0;
    logic [1:0]        cfg_index = igtt_pkg::REG_IOU_THRESHOLD;
    logic [15:0]       cfg_data = '0;

    int unsigned cycle_count = 0;
    int unsigned fail_count = 0;
    int unsigned hold_left = 0;
    bit          no_idle = 1'b0;

    igtt_pkg::result_t pending_results[$];

    // mirror of the track table
    logic [11:0] trk_l[SLOTS], trk_t[SLOTS], trk_w[SLOTS], trk_h[SLOTS];
    logic [7:0]  trk_class[SLOTS];
    logic [15:0] trk_ident[SLOTS];
    logic [7:0]  trk_age[SLOTS];
    bit          trk_live[SLOTS];
    bit          trk_fresh[SLOTS];
    logic [15:0] next_ident;
    logic [8:0]  live_total;
    logic [15:0] thr_reg;
    logic [7:0]  age_limit;

    // objects the random frames follow
    igtt_pkg::item_t scene[8];

    iou_greedy_track_table uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        r = int'($urandom_range(0, 99));
        if (no_idle || r < 60)
            return 0;
        if (r < 92)
            return int'($urandom_range(1, 3));
        return int'($urandom_range(10, 60));
    endfunction

    // receiver side
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            result_stall <= 1'b1;
        end
        else if (no_idle)
            result_stall <= 1'b0;
        else
            result_stall <= ($urandom_range(0, 99) < 25);
    end

    always @(posedge clk)
    begin
        igtt_pkg::result_t exp_r;
        if (rst_n && result_valid && !result_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result transaction with nothing expected");
                fail_count++;
            end
            else
            begin
                exp_r = pending_results.pop_front();
                if (result.assigned_id !== exp_r.assigned_id)
                begin
                    $error("assigned_id expected %0d got %0d", exp_r.assigned_id,
                           result.assigned_id);
                    fail_count++;
                end
                if (result.is_new !== exp_r.is_new)
                begin
                    $error("is_new expected %0d got %0d", exp_r.is_new, result.is_new);
                    fail_count++;
                end
                if (result.table_full !== exp_r.table_full)
                begin
                    $error("table_full expected %0d got %0d", exp_r.table_full,
                           result.table_full);
                    fail_count++;
                end
                if (result.live_count !== exp_r.live_count)
                begin
                    $error("live_count expected %0d got %0d", exp_r.live_count,
                           result.live_count);
                    fail_count++;
                end
                if (result.ids_issued !== exp_r.ids_issued)
                begin
                    $error("ids_issued expected %0d got %0d", exp_r.ids_issued,
                           result.ids_issued);
                    fail_count++;
                end
            end
        end
    end

    function automatic void wipe_tracks();
        for (int i = 0; i < SLOTS; i++)
        begin
            trk_live[i] = 1'b0;
            trk_fresh[i] = 1'b0;
        end
        next_ident = 16'd1;
        live_total = '0;
    endfunction

    function automatic void box_overlap(int i, igtt_pkg::item_t d,
                                        output longint unsigned inter,
                                        output longint unsigned uni);
        longint x1, y1, x2, y2, pr, qr, pb, qb, iw, ih;
        x1 = (trk_l[i] > d.box_left) ? trk_l[i] : d.box_left;
        y1 = (trk_t[i] > d.box_top) ? trk_t[i] : d.box_top;
        pr = longint'(trk_l[i]) + trk_w[i];
        qr = longint'(d.box_left) + d.box_width;
        pb = longint'(trk_t[i]) + trk_h[i];
        qb = longint'(d.box_top) + d.box_height;
        x2 = (pr < qr) ? pr : qr;
        y2 = (pb < qb) ? pb : qb;
        iw = (x2 > x1) ? x2 - x1 : 0;
        ih = (y2 > y1) ? y2 - y1 : 0;
        inter = iw * ih;
        uni = longint'(trk_w[i]) * trk_h[i] + longint'(d.box_width) * d.box_height - inter;
    endfunction

    function automatic igtt_pkg::result_t track_update(igtt_pkg::item_t d);
        igtt_pkg::result_t r;
        int best, slot, aged;
        longint unsigned inter, uni, best_i, best_u;
        bit take;
        r = '0;
        best = -1;
        best_i = 0;
        best_u = 0;
        if (d.kind == igtt_pkg::KIND_DET)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                if (trk_live[i] && !trk_fresh[i] && trk_class[i] == d.det_class)
                begin
                    box_overlap(i, d, inter, uni);
                    if (best < 0)
                        take = (inter * 65536) > (longint'(thr_reg) * uni);
                    else
                        take = (inter * best_u) > (best_i * uni);
                    if (take)
                    begin
                        best = i;
                        best_i = inter;
                        best_u = uni;
                    end
                end
            end
            slot = best;
            if (slot < 0)
            begin
                for (int i = 0; i < SLOTS; i++)
                    if (!trk_live[i] && slot < 0)
                        slot = i;
            end
            if (best < 0 && slot < 0)
                r.table_full = 1'b1;
            else
            begin
                trk_l[slot] = d.box_left;
                trk_t[slot] = d.box_top;
                trk_w[slot] = d.box_width;
                trk_h[slot] = d.box_height;
                trk_age[slot] = '0;
                trk_fresh[slot] = 1'b1;
                if (best >= 0)
                    r.assigned_id = trk_ident[slot];
                else
                begin
                    trk_class[slot] = d.det_class;
                    trk_ident[slot] = next_ident;
                    trk_live[slot] = 1'b1;
                    live_total++;
                    r.assigned_id = next_ident;
                    r.is_new = 1'b1;
                    next_ident++;
                    if (next_ident == 16'd0)
                        next_ident = 16'd1;
                end
            end
        end
        else if (d.kind == igtt_pkg::KIND_EOF)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                if (trk_live[i] && !trk_fresh[i])
                begin
                    aged = int'(trk_age[i]) + 1;
                    if (aged > int'(age_limit))
                    begin
                        trk_live[i] = 1'b0;
                        live_total--;
                    end
                    else
                        trk_age[i] = aged[7:0];
                end
                trk_fresh[i] = 1'b0;
            end
        end
        else if (d.kind == igtt_pkg::KIND_CLEAR)
            wipe_tracks();
        r.live_count = live_total;
        r.ids_issued = next_ident - 16'd1;
        return r;
    endfunction

    // called and returns at a falling edge
    task automatic send_item(igtt_pkg::item_t d);
        int gap;
        item <= d;
        item_valid <= 1'b1;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        pending_results.push_back(track_update(d));
        @(negedge clk);
        gap = pick_gap();
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    task automatic drain();
        item_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] value);
        drain();
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(negedge clk);
        cfg_write <= 1'b0;
        if (idx == igtt_pkg::REG_IOU_THRESHOLD)
            thr_reg = value;
        else if (idx == igtt_pkg::REG_MAX_AGE)
            age_limit = value[7:0];
    endtask

    function automatic igtt_pkg::item_t make_item(igtt_pkg::igtt_kind_t k, logic [7:0] c,
                                                  logic [11:0] l, logic [11:0] t,
                                                  logic [11:0] w, logic [11:0] h);
        igtt_pkg::item_t d;
        d.kind = k;
        d.det_class = c;
        d.box_left = l;
        d.box_top = t;
        d.box_width = w;
        d.box_height = h;
        return d;
    endfunction

    function automatic igtt_pkg::item_t wild_item(igtt_pkg::igtt_kind_t k);
        igtt_pkg::item_t d;
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        d = raw[$bits(igtt_pkg::item_t)-1:0];
        d.kind = k;
        return d;
    endfunction

    task automatic test_directed();
        send_item(make_item(igtt_pkg::KIND_DET, 8'd255, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF));
        send_item(make_item(igtt_pkg::KIND_DET, 8'd0, 12'd0, 12'd0, 12'd0, 12'd0));
        send_item(make_item(igtt_pkg::KIND_EOF, 8'd0, 12'd0, 12'd0, 12'd0, 12'd0));
        // same box again matches, zero-area box never matches
        send_item(make_item(igtt_pkg::KIND_DET, 8'd255, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF));
        send_item(make_item(igtt_pkg::KIND_DET, 8'd0, 12'd0, 12'd0, 12'd0, 12'd0));
        send_item(make_item(igtt_pkg::KIND_DET, 8'd255, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF));
        send_item(make_item(igtt_pkg::KIND_NONE, 8'hAA, 12'h555, 12'hAAA, 12'h555, 12'hAAA));
        send_item(make_item(igtt_pkg::KIND_DET, 8'd7, 12'd100, 12'd100, 12'd50, 12'd50));
        send_item(make_item(igtt_pkg::KIND_DET, 8'd7, 12'd300, 12'd100, 12'd50, 12'd50));
        send_item(make_item(igtt_pkg::KIND_EOF, 8'd0, 12'd0, 12'd0, 12'd0, 12'd0));
        // partial overlaps: a shift matches its track above threshold, the middle box opens a new one
        send_item(make_item(igtt_pkg::KIND_DET, 8'd7, 12'd110, 12'd100, 12'd50, 12'd50));
        send_item(make_item(igtt_pkg::KIND_DET, 8'd7, 12'd330, 12'd100, 12'd50, 12'd50));
        send_item(make_item(igtt_pkg::KIND_DET, 8'd7, 12'd200, 12'd100, 12'd100, 12'd50));
        send_item(make_item(igtt_pkg::KIND_EOF, 8'd0, 12'd0, 12'd0, 12'd0, 12'd0));
        send_item(make_item(igtt_pkg::KIND_EOF, 8'd0, 12'd0, 12'd0, 12'd0, 12'd0));
        send_item(make_item(igtt_pkg::KIND_CLEAR, 8'd0, 12'd0, 12'd0, 12'd0, 12'd0));
        send_item(make_item(igtt_pkg::KIND_DET, 8'd1, 12'd0, 12'd0, 12'd1, 12'd1));
    endtask

    task automatic test_table_full();
        write_reg(igtt_pkg::REG_MAX_AGE, 16'd0);
        send_item(make_item(igtt_pkg::KIND_CLEAR, 8'd0, 12'd0, 12'd0, 12'd0, 12'd0));
        for (int i = 0; i < SLOTS + 3; i++)
            send_item(make_item(igtt_pkg::KIND_DET, 8'd3, 12'($urandom), 12'($urandom),
                                12'd0, 12'($urandom)));
        send_item(make_item(igtt_pkg::KIND_EOF, 8'd0, 12'd0, 12'd0, 12'd0, 12'd0));
        send_item(make_item(igtt_pkg::KIND_DET, 8'd3, 12'd5, 12'd5, 12'd0, 12'd0));
        send_item(make_item(igtt_pkg::KIND_EOF, 8'd0, 12'd0, 12'd0, 12'd0, 12'd0));
        // freed slots are handed out again
        send_item(make_item(igtt_pkg::KIND_DET, 8'd3, 12'd5, 12'd5, 12'd9, 12'd9));
    endtask

    task automatic test_age_overflow();
        write_reg(igtt_pkg::REG_MAX_AGE, 16'd255);
        no_idle = 1'b1;
        send_item(make_item(igtt_pkg::KIND_CLEAR, 8'd0, 12'd0, 12'd0, 12'd0, 12'd0));
        send_item(make_item(igtt_pkg::KIND_DET, 8'd9, 12'd40, 12'd40, 12'd20, 12'd20));
        for (int i = 0; i < SLOTS + 3; i++)
            send_item(make_item(igtt_pkg::KIND_EOF, 8'd0, 12'd0, 12'd0, 12'd0, 12'd0));
        no_idle = 1'b0;
    endtask

    task automatic test_backpressure();
        drain();
        hold_left = 4000;
        for (int i = 0; i < 8; i++)
            send_item(wild_item(i % 3 == 2 ? igtt_pkg::KIND_EOF : igtt_pkg::KIND_DET));
    endtask

    task automatic test_random_frames(int count);
        igtt_pkg::item_t d;
        int k, sent, dets;
        sent = 0;
        for (int i = 0; i < 8; i++)
        begin
            scene[i] = make_item(igtt_pkg::KIND_DET, 8'($urandom_range(0, 3)),
                                 12'($urandom_range(0, 3800)), 12'($urandom_range(0, 3800)),
                                 12'($urandom_range(8, 200)), 12'($urandom_range(8, 200)));
        end
        while (sent < count)
        begin
            dets = int'($urandom_range(1, 6));
            for (int j = 0; j < dets; j++)
            begin
                k = int'($urandom_range(0, 99));
                if (k < 70)
                begin
                    // object moves a little
                    d = scene[$urandom_range(0, 7)];
                    d.box_left = d.box_left + 12'($urandom_range(0, 8)) - 12'd4;
                    d.box_top = d.box_top + 12'($urandom_range(0, 8)) - 12'd4;
                    d.box_width = d.box_width + 12'($urandom_range(0, 4)) - 12'd2;
                    d.box_height = d.box_height + 12'($urandom_range(0, 4)) - 12'd2;
                    scene[$urandom_range(0, 7)] = d;
                end
                else if (k < 90)
                    d = wild_item(igtt_pkg::KIND_DET);
                else if (k < 94)
                    d = wild_item(igtt_pkg::KIND_NONE);
                else if (k < 96)
                    d = wild_item(igtt_pkg::KIND_CLEAR);
                else
                    d = wild_item(igtt_pkg::KIND_EOF);
                send_item(d);
                sent++;
            end
            send_item(wild_item(igtt_pkg::KIND_EOF));
            sent++;
            if ($urandom_range(0, 9) == 0)
                no_idle = ~no_idle;
        end
        no_idle = 1'b0;
    endtask

    initial
    begin
        thr_reg = igtt_pkg::THR_RESET;
        age_limit = igtt_pkg::AGE_RESET;
        wipe_tracks();
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_directed();
        write_reg(igtt_pkg::REG_IOU_THRESHOLD, 16'd0);
        test_directed();
        test_table_full();
        test_age_overflow();
        write_reg(igtt_pkg::REG_IOU_THRESHOLD, 16'hFFFF);
        write_reg(igtt_pkg::REG_MAX_AGE, 16'd2);
        test_backpressure();
        test_random_frames(150);
        write_reg(igtt_pkg::REG_IOU_THRESHOLD, 16'd0);
        write_reg(igtt_pkg::REG_MAX_AGE, 16'd0);
        test_random_frames(150);
        write_reg(igtt_pkg::REG_IOU_THRESHOLD, igtt_pkg::THR_RESET);
        write_reg(igtt_pkg::REG_MAX_AGE, 16'(igtt_pkg::AGE_RESET));
        test_random_frames(200);
        write_reg(igtt_pkg::REG_IOU_THRESHOLD, 16'($urandom_range(1000, 60000)));
        write_reg(igtt_pkg::REG_MAX_AGE, 16'($urandom_range(1, 254)));
        test_random_frames(150);

        drain();
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
